// ===== design/ppr_pkg.sv =====
// shared definitions for the ping-pong record buffer
// field widths, action codes and default buffer size; no dependencies
package ppr_pkg;

  localparam int CHUNK_SIZE_DEF = 4096;

  localparam int ACTION_W = 2;
  localparam int LEN_W    = 13;
  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 12;
  localparam int FILL_W   = 13;
  localparam int CNT_W    = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_BEGIN = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

endpackage

// ===== design/ppr_ram.sv =====
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module ppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ping_pong_record_buffer.sv =====
// top level of the ping-pong record buffer
// uses ppr_pkg (widths, action codes) and ppr_ram (byte store)
//
// Two byte buffers of CHUNK_SIZE bytes each share one ram of 2*CHUNK_SIZE
// bytes and take records in turn. Every item gives exactly one result item.
// The block takes one item per cycle while the output is not stalled; a result
// passes through stage one, where the registered ram read completes, and then the
// output register; a stalled output holds the pipeline back through in_ready.
// Offset, flags and counters sit in registers and are updated in the cycle
// the item is accepted; each item makes at most one ram access, so a read that
// follows a write to the same byte sees the new data without forwarding.
// No clearing pass is needed after reset: a read of a byte never written is
// undefined.
module ping_pong_record_buffer #(
  parameter int CHUNK_SIZE = ppr_pkg::CHUNK_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ppr_pkg::ACTION_W-1:0]  action,
  input  logic [ppr_pkg::LEN_W-1:0]     record_length,
  input  logic [ppr_pkg::BYTE_W-1:0]    data_byte,
  input  logic                          buffer_select,
  input  logic [ppr_pkg::ADDR_W-1:0]    byte_address,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          push_ok,
  output logic [ppr_pkg::BYTE_W-1:0]    read_value,
  output logic                          ready_first,
  output logic                          ready_second,
  output logic                          active_buffer,
  output logic [ppr_pkg::FILL_W-1:0]    active_fill,
  output logic [ppr_pkg::CNT_W-1:0]     swap_total,
  output logic [ppr_pkg::CNT_W-1:0]     drop_total,
  output logic [ppr_pkg::CNT_W-1:0]     fill_events_selected
);

  import ppr_pkg::*;

  // offset must hold CHUNK_SIZE itself (buffer full)
  localparam int OW = $clog2(CHUNK_SIZE + 1);
  localparam int DEPTH = 2 * CHUNK_SIZE;
  localparam int AW = $clog2(DEPTH);
  // width for the fit check: offset plus announced length
  localparam int SW = ((OW > LEN_W) ? OW : LEN_W) + 1;
  // width for the read address range check
  localparam int RW = (AW > ADDR_W) ? AW : ADDR_W;

  typedef struct packed {
    logic              ok;
    logic              rd_use;
    logic              ready0;
    logic              ready1;
    logic              active;
    logic [FILL_W-1:0] fill;
    logic [CNT_W-1:0]  swaps;
    logic [CNT_W-1:0]  drops;
    logic [CNT_W-1:0]  fev;
  } result_t;

  // architectural state
  logic              active_idx, active_idx_next;
  logic [OW-1:0]     offset, offset_next;
  logic [1:0]        ready_flags, ready_flags_next;
  logic [CNT_W-1:0]  full_cnt [2];
  logic [CNT_W-1:0]  full_cnt_next [2];
  logic [CNT_W-1:0]  swap_cnt, swap_cnt_next;
  logic [CNT_W-1:0]  drop_cnt, drop_cnt_next;
  logic              discarding, discarding_next;

  // pipeline: stage one waits for ram data, then the output register
  logic              s1_vld;
  result_t           s1_res;
  result_t           res_next;
  logic              out_vld;
  result_t           out_res;
  logic [BYTE_W-1:0] out_rd;

  logic              in_acc;
  logic              s1_move;
  action_t           act;
  logic              other;
  logic [SW-1:0]     fit_sum;
  logic              overflow;
  logic              rd_in_range;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  assign s1_move  = s1_vld && (!out_vld || out_ready);
  assign in_ready = !s1_vld || s1_move;
  assign in_acc   = in_valid && in_ready;

  assign act         = action_t'(action);
  assign other       = ~active_idx;
  assign fit_sum     = SW'(offset) + SW'(record_length);
  assign overflow    = fit_sum > SW'(CHUNK_SIZE);
  assign rd_in_range = RW'(byte_address) < RW'(CHUNK_SIZE);

  // second buffer starts at CHUNK_SIZE in the shared ram
  assign ram_waddr = (active_idx ? AW'(CHUNK_SIZE) : '0) + AW'(offset);
  assign ram_raddr = (buffer_select ? AW'(CHUNK_SIZE) : '0) + AW'(byte_address);

  // next state and result of the item on the input port
  always_comb begin
    active_idx_next  = active_idx;
    offset_next      = offset;
    ready_flags_next = ready_flags;
    full_cnt_next[0] = full_cnt[0];
    full_cnt_next[1] = full_cnt[1];
    swap_cnt_next    = swap_cnt;
    drop_cnt_next    = drop_cnt;
    discarding_next  = discarding;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    res_next         = '0;
    case (act)
      ACT_BEGIN: begin
        res_next.ok     = 1'b1;
        discarding_next = 1'b0;
        if (overflow) begin
          // active buffer is done, whether or not we can swap
          ready_flags_next[active_idx] = 1'b1;
          full_cnt_next[active_idx]    = full_cnt[active_idx] + 1'b1;
          if (ready_flags[other]) begin
            // other buffer not yet drained: drop this record
            drop_cnt_next   = drop_cnt + 1'b1;
            discarding_next = 1'b1;
            res_next.ok     = 1'b0;
          end else begin
            active_idx_next = other;
            offset_next     = '0;
            swap_cnt_next   = swap_cnt + 1'b1;
          end
        end
      end
      ACT_WRITE: begin
        if (!discarding && (offset < OW'(CHUNK_SIZE))) begin
          ram_we      = in_acc;
          offset_next = offset + 1'b1;
          res_next.ok = 1'b1;
        end
      end
      ACT_FREE: begin
        ready_flags_next[buffer_select] = 1'b0;
      end
      ACT_READ: begin
        // out of range reads give zero and leave the ram alone
        ram_re          = in_acc && rd_in_range;
        res_next.rd_use = rd_in_range;
      end
      default: begin
      end
    endcase
    res_next.ready0 = ready_flags_next[0];
    res_next.ready1 = ready_flags_next[1];
    res_next.active = active_idx_next;
    res_next.fill   = FILL_W'(offset_next);
    res_next.swaps  = swap_cnt_next;
    res_next.drops  = drop_cnt_next;
    res_next.fev    = full_cnt_next[buffer_select];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_idx  <= 1'b0;
      offset      <= '0;
      ready_flags <= '0;
      full_cnt[0] <= '0;
      full_cnt[1] <= '0;
      swap_cnt    <= '0;
      drop_cnt    <= '0;
      discarding  <= 1'b0;
    end else if (in_acc) begin
      active_idx  <= active_idx_next;
      offset      <= offset_next;
      ready_flags <= ready_flags_next;
      full_cnt[0] <= full_cnt_next[0];
      full_cnt[1] <= full_cnt_next[1];
      swap_cnt    <= swap_cnt_next;
      drop_cnt    <= drop_cnt_next;
      discarding  <= discarding_next;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld <= 1'b1;
      end else if (s1_move) begin
        s1_vld <= 1'b0;
      end
      if (s1_move) begin
        out_vld <= 1'b1;
      end else if (out_ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // pipeline payload; ram data is valid while its item sits in stage one
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res <= res_next;
    end
    if (s1_move) begin
      out_res <= s1_res;
      out_rd  <= s1_res.rd_use ? ram_rdata : '0;
    end
  end

  ppr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid            = out_vld;
  assign push_ok              = out_res.ok;
  assign read_value           = out_rd;
  assign ready_first          = out_res.ready0;
  assign ready_second         = out_res.ready1;
  assign active_buffer        = out_res.active;
  assign active_fill          = out_res.fill;
  assign swap_total           = out_res.swaps;
  assign drop_total           = out_res.drops;
  assign fill_events_selected = out_res.fev;

  // the ram is only written inside the active buffer and never while discarding
  a_write_in_bounds: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (!discarding && (offset < OW'(CHUNK_SIZE))))
    else $error("byte write outside active buffer");

  // fill offset never passes the buffer end
  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    offset <= OW'(CHUNK_SIZE))
    else $error("write offset beyond buffer end");

  // a refused begin record leaves the block discarding
  a_drop_discards: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (act == ACT_BEGIN) && !res_next.ok) |=> discarding)
    else $error("dropped record not discarded");

  // a swap flips the active buffer and restarts at offset zero
  a_swap_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (swap_cnt_next != swap_cnt)) |=>
      ((offset == '0) && (active_idx != $past(active_idx))))
    else $error("swap without restart");

  // a stalled stage one never sees a new ram access
  a_no_ram_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_vld && !s1_move) |-> (!ram_re && !ram_we))
    else $error("ram access while stage one stalled");

endmodule

// ===== tb/ping_pong_record_buffer_test.sv =====
// self-checking testbench for the ping-pong record buffer: random and directed items,
// every result predicted in the bench and compared field by field
// depends on ppr_pkg and the ping_pong_record_buffer top level
module ping_pong_record_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ppr_pkg::*;

  localparam int CHUNK       = CHUNK_SIZE_DEF;
  localparam int QUEUE_AHEAD = 4;     // items kept waiting ahead of the driver
  localparam int IDLE_PCT    = 18;    // chance of a gap or stall in a cycle
  localparam int RANDOM_ITEMS = 1250;

  // one input item, as it sits on the input ports
  typedef struct packed {
    action_t            act;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  data;
    logic               sel;
    logic [ADDR_W-1:0]  addr;
  } record_item_t;

  // one result item, as it sits on the output ports
  typedef struct packed {
    logic               push_ok;
    logic [BYTE_W-1:0]  read_value;
    logic               ready_first;
    logic               ready_second;
    logic               active_buffer;
    logic [FILL_W-1:0]  active_fill;
    logic [CNT_W-1:0]   swap_total;
    logic [CNT_W-1:0]   drop_total;
    logic [CNT_W-1:0]   fill_events_selected;
  } outcome_t;

  // ports of the block; those the bench drives are known from time zero
  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic [ACTION_W-1:0] action        = ACT_READ;
  logic [LEN_W-1:0]    record_length = '0;
  logic [BYTE_W-1:0]   data_byte     = '0;
  logic                buffer_select = 1'b0;
  logic [ADDR_W-1:0]   byte_address  = '0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic                push_ok;
  logic [BYTE_W-1:0]   read_value;
  logic                ready_first;
  logic                ready_second;
  logic                active_buffer;
  logic [FILL_W-1:0]   active_fill;
  logic [CNT_W-1:0]    swap_total;
  logic [CNT_W-1:0]    drop_total;
  logic [CNT_W-1:0]    fill_events_selected;

  ping_pong_record_buffer #(.CHUNK_SIZE(CHUNK)) dut (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .action               (action),
    .record_length        (record_length),
    .data_byte            (data_byte),
    .buffer_select        (buffer_select),
    .byte_address         (byte_address),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .push_ok              (push_ok),
    .read_value           (read_value),
    .ready_first          (ready_first),
    .ready_second         (ready_second),
    .active_buffer        (active_buffer),
    .active_fill          (active_fill),
    .swap_total           (swap_total),
    .drop_total           (drop_total),
    .fill_events_selected (fill_events_selected)
  );

  // ---------------------------------------------------------------------------
  // bench copy of the buffer state, starting from the reset values
  // ---------------------------------------------------------------------------
  logic              active_idx      = 1'b0;
  int                fill_offset     = 0;
  logic              ready_flag [2]  = '{1'b0, 1'b0};
  logic [CNT_W-1:0]  full_events [2] = '{'0, '0};
  logic [CNT_W-1:0]  swaps           = '0;
  logic [CNT_W-1:0]  drops           = '0;
  bit                dropping        = 1'b0;
  logic [BYTE_W-1:0] stored_bytes [2*CHUNK];
  // writes always run upwards from offset zero, so the bytes ever written in
  // a buffer form a prefix of it; reads are only aimed inside that prefix
  int                written_top [2] = '{0, 0};
  bit                have_last_byte  = 1'b0;
  logic              last_buf        = 1'b0;
  int                last_off        = 0;

  // run statistics
  int reads_done     = 0;
  int bytes_refused  = 0;
  int items_queued   = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int failures       = 0;

  record_item_t items_to_send [$];
  outcome_t     predicted_outcomes [$];
  record_item_t on_port;

  // a stretch with no random gaps and no stalls, inside the random part
  logic quiet_stretch;
  assign quiet_stretch = (items_accepted >= 300) && (items_accepted < 900);

  // apply one accepted item to the bench state and return the result it gives
  function automatic outcome_t apply_to_buffers(input record_item_t it);
    outcome_t o;
    o = '0;
    case (it.act)
      ACT_BEGIN: begin
        o.push_ok = 1'b1;
        // record does not fit: active buffer is full, whatever happens next
        if (fill_offset + int'(it.len) > CHUNK) begin
          ready_flag[active_idx]  = 1'b1;
          full_events[active_idx] = full_events[active_idx] + 1'b1;
          if (ready_flag[!active_idx]) begin
            // other buffer not yet drained: the record is dropped
            drops     = drops + 1'b1;
            dropping  = 1'b1;
            o.push_ok = 1'b0;
          end else begin
            active_idx  = !active_idx;
            fill_offset = 0;
            swaps       = swaps + 1'b1;
          end
        end
        if (o.push_ok) dropping = 1'b0;
      end
      ACT_WRITE: begin
        // bytes of a dropped record and bytes past the buffer end are refused
        if (dropping || fill_offset >= CHUNK) begin
          bytes_refused++;
        end else begin
          stored_bytes[int'(active_idx) * CHUNK + fill_offset] = it.data;
          last_buf       = active_idx;
          last_off       = fill_offset;
          have_last_byte = 1'b1;
          fill_offset++;
          if (fill_offset > written_top[active_idx])
            written_top[active_idx] = fill_offset;
          o.push_ok = 1'b1;
        end
      end
      ACT_FREE: begin
        ready_flag[it.sel] = 1'b0;
      end
      ACT_READ: begin
        reads_done++;
        // an address past the buffer end reads as zero
        if (int'(it.addr) < CHUNK)
          o.read_value = stored_bytes[int'(it.sel) * CHUNK + int'(it.addr)];
      end
    endcase
    o.ready_first          = ready_flag[0];
    o.ready_second         = ready_flag[1];
    o.active_buffer        = active_idx;
    o.active_fill          = fill_offset[FILL_W-1:0];
    o.swap_total           = swaps;
    o.drop_total           = drops;
    o.fill_events_selected = full_events[it.sel];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // driver: takes items from the pending queue; an item that is accepted is
  // handed to the predictor in the same edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_outcomes.push_back(apply_to_buffers(on_port));
        items_accepted++;
      end
      // a new item may only go on the port once the current one has gone
      if (!in_valid || in_ready) begin
        if (items_to_send.size() != 0 &&
            (quiet_stretch || $urandom_range(99) >= IDLE_PCT)) begin
          on_port       = items_to_send.pop_front();
          in_valid      <= 1'b1;
          action        <= on_port.act;
          record_length <= on_port.len;
          data_byte     <= on_port.data;
          buffer_select <= on_port.sel;
          byte_address  <= on_port.addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: stalls at random and checks every result taken
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string text);
    failures++;
    $display("mismatch: %s", text);
  endtask

  task automatic compare_field(input string name, input logic [CNT_W-1:0] got,
                               input logic [CNT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                results_checked, name, got, want));
  endtask

  task automatic check_outcome();
    outcome_t want;
    if (predicted_outcomes.size() == 0) begin
      report_mismatch($sformatf("result after %0d checked arrived with none expected",
                                results_checked));
    end else begin
      want = predicted_outcomes.pop_front();
      compare_field("push_ok", CNT_W'(push_ok), CNT_W'(want.push_ok));
      compare_field("read_value", CNT_W'(read_value), CNT_W'(want.read_value));
      compare_field("ready_first", CNT_W'(ready_first), CNT_W'(want.ready_first));
      compare_field("ready_second", CNT_W'(ready_second), CNT_W'(want.ready_second));
      compare_field("active_buffer", CNT_W'(active_buffer), CNT_W'(want.active_buffer));
      compare_field("active_fill", CNT_W'(active_fill), CNT_W'(want.active_fill));
      compare_field("swap_total", swap_total, want.swap_total);
      compare_field("drop_total", drop_total, want.drop_total);
      compare_field("fill_events_selected", fill_events_selected,
                    want.fill_events_selected);
      results_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_outcome();
      out_ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers; they run on the falling edge so that the bench state
  // they look at has settled
  // ---------------------------------------------------------------------------

  // queue one item; a negative field value means a random one, a length only up to CHUNK
  task automatic push_item(input action_t act, input int len, input int dat,
                           input int sel, input int addr);
    record_item_t it;
    while (items_to_send.size() >= QUEUE_AHEAD) @(negedge clk);
    it.act  = act;
    it.len  = (len < 0) ? LEN_W'($urandom_range(0, CHUNK)) : LEN_W'(len);
    it.data = (dat < 0) ? BYTE_W'($urandom_range(255)) : BYTE_W'(dat);
    it.sel  = (sel < 0) ? 1'($urandom_range(1)) : 1'(sel);
    it.addr = (addr < 0) ? ADDR_W'($urandom_range((1 << ADDR_W) - 1)) : ADDR_W'(addr);
    items_to_send.push_back(it);
    items_queued++;
  endtask

  // wait until nothing is pending, on the port or still expected
  task automatic wait_drained();
    while (items_to_send.size() != 0 || in_valid || predicted_outcomes.size() != 0)
      @(negedge clk);
  endtask

  // read a byte known to be written: either the newest stored byte, right after
  // it went in, or anywhere in the written part of a buffer
  task automatic push_read(input int sel, input bit newest);
    int pick;
    bit done;
    done = 1'b0;
    if (newest) begin
      while (items_to_send.size() != 0 || in_valid) @(negedge clk);
      if (have_last_byte) begin
        push_item(ACT_READ, -1, -1, int'(last_buf), last_off);
        done = 1'b1;
      end
    end
    if (!done) begin
      pick = (written_top[sel] != 0) ? sel : 1 - sel;
      if (written_top[pick] != 0)
        push_item(ACT_READ, -1, -1, pick, $urandom_range(0, written_top[pick] - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int start;
    int r;
    int len;
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty record, byte extremes, read back
    push_item(ACT_BEGIN, 0, -1, -1, -1);
    push_item(ACT_WRITE, -1, 8'h00, -1, -1);
    push_item(ACT_WRITE, -1, 8'hff, -1, -1);
    push_item(ACT_WRITE, -1, 8'ha5, -1, -1);
    push_item(ACT_READ, -1, -1, 0, 0);
    push_item(ACT_READ, -1, -1, 0, 2);
    // longest record does not fit behind three bytes: buffer 0 full, swap
    push_item(ACT_BEGIN, CHUNK, -1, -1, -1);
    push_item(ACT_WRITE, -1, 8'h5a, -1, -1);
    // buffer 1 full while buffer 0 still waits: record dropped, bytes refused
    push_item(ACT_BEGIN, CHUNK, -1, -1, -1);
    push_item(ACT_WRITE, -1, -1, -1, -1);
    push_item(ACT_WRITE, -1, -1, -1, -1);
    // full again while still full: another fill event and another drop
    push_item(ACT_BEGIN, CHUNK, -1, -1, -1);
    // drain buffer 0, then the next long record swaps back to it
    push_item(ACT_FREE, -1, -1, 0, -1);
    push_item(ACT_BEGIN, CHUNK, -1, -1, -1);
    // short record: fewer bytes than announced
    push_item(ACT_BEGIN, 2, -1, -1, -1);
    push_item(ACT_WRITE, -1, -1, -1, -1);
    // more bytes than announced, still inside the buffer
    push_item(ACT_BEGIN, 1, -1, -1, -1);
    repeat (3) push_item(ACT_WRITE, -1, -1, -1, -1);
    push_item(ACT_READ, -1, -1, 1, 0);
    push_item(ACT_READ, -1, -1, 0, 1);
    push_item(ACT_FREE, -1, -1, 1, -1);
    push_item(ACT_FREE, -1, -1, 0, -1);

    // sender holds off until every result is back
    wait_drained();

    // a whole-buffer record does not fit behind the bytes already in buffer 0:
    // swap to buffer 1, which restarts at offset zero
    push_item(ACT_BEGIN, CHUNK, -1, -1, -1);
    repeat (16) push_item(ACT_WRITE, -1, -1, -1, -1);
    push_read(1, 1'b1);
    repeat (4) push_read(1, 1'b0);
    push_item(ACT_FREE, -1, -1, 0, -1);
    push_item(ACT_FREE, -1, -1, 1, -1);

    // random: mostly records (begin then bytes), mixed with frees, reads and noise
    start = items_queued;
    while (items_queued - start < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 8) begin
        n = $urandom_range(3);
        if (action_t'(n) == ACT_READ) push_read($urandom_range(1), 1'b0);
        else push_item(action_t'(n), -1, -1, -1, -1);
      end else if (r < 18) begin
        push_item(ACT_FREE, -1, -1, -1, -1);
      end else if (r < 30) begin
        push_read($urandom_range(1), $urandom_range(3) == 0);
      end else begin
        if ($urandom_range(3) == 0) begin
          // long announcement, usually forcing a full buffer
          len = $urandom_range(3800, CHUNK);
          n   = $urandom_range(12);
        end else begin
          len = $urandom_range(40);
          n   = len - 3 + int'($urandom_range(6));
          if (n < 0) n = 0;
        end
        push_item(ACT_BEGIN, len, -1, -1, -1);
        repeat (n) push_item(ACT_WRITE, -1, -1, -1, -1);
      end
    end

    wait_drained();
    // catch any stray result after the last one expected
    repeat (8) @(negedge clk);

    $display("%0d items: %0d swaps, %0d dropped records, %0d bytes refused, %0d reads",
             items_accepted, swaps, drops, bytes_refused, reads_done);
    $display("%0d results compared, %0d mismatches", results_checked, failures);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("timed out with %0d results still expected", predicted_outcomes.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
